### hdl/nvpm_pkg.sv
// Shared types and constants of the note velocity peak meter.
`timescale 1ns / 1ps
`default_nettype none

package nvpm_pkg;

  localparam int unsigned NOTE_W             = 7;
  localparam int unsigned VEL_W              = 7;
  localparam int unsigned LEVEL_W            = 7;
  localparam int unsigned CFG_W              = 7;
  localparam int unsigned NOTE_COUNT_DEFAULT = 128;

  localparam logic [CFG_W-1:0] DECAY_STEP_RESET     = 7'd5;
  localparam logic [CFG_W-1:0] SNAP_THRESHOLD_RESET = 7'd10;

  typedef enum logic [1:0] {
    CMD_NOTE_ON  = 2'd0,
    CMD_NOTE_OFF = 2'd1,
    CMD_TICK     = 2'd2
  } cmd_e;

  typedef enum logic {
    CFG_DECAY_STEP     = 1'b0,
    CFG_SNAP_THRESHOLD = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  velocity;
  } in_req_t;

  typedef struct packed {
    logic [NOTE_W-1:0]  peak_note;
    logic [VEL_W-1:0]   peak_velocity;
    logic [LEVEL_W-1:0] level;
    logic               redraw;
  } out_rsp_t;

  typedef struct packed {
    logic [CFG_W-1:0] decay_step;
    logic [CFG_W-1:0] snap_threshold;
  } cfg_t;

endpackage

`default_nettype wire

### hdl/nvpm_ram.sv
// Per-note velocity store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module nvpm_ram #(
  parameter int unsigned NOTE_COUNT = nvpm_pkg::NOTE_COUNT_DEFAULT,
  parameter int unsigned IDX_W      = $clog2(NOTE_COUNT)
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [IDX_W-1:0]           waddr_i,
  input  wire logic [nvpm_pkg::VEL_W-1:0] wdata_i,
  input  wire logic                       re_i,
  input  wire logic [IDX_W-1:0]           raddr_i,
  output logic      [nvpm_pkg::VEL_W-1:0] rdata_o
);
  import nvpm_pkg::*;

  logic [VEL_W-1:0] mem [NOTE_COUNT];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

### hdl/nvpm_scan.sv
// Rescan sequencer: walks the store one read per cycle and keeps the lowest maximum.
`timescale 1ns / 1ps
`default_nettype none

module nvpm_scan #(
  parameter int unsigned NOTE_COUNT = nvpm_pkg::NOTE_COUNT_DEFAULT,
  parameter int unsigned IDX_W      = $clog2(NOTE_COUNT)
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  output logic                            rd_en_o,
  output logic      [IDX_W-1:0]           rd_addr_o,
  input  wire logic [nvpm_pkg::VEL_W-1:0] rd_data_i,
  output logic                            busy_o,
  output logic                            done_o,
  output logic      [IDX_W-1:0]           best_idx_o,
  output logic      [nvpm_pkg::VEL_W-1:0] best_vel_o
);
  import nvpm_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NOTE_COUNT - 1);

  logic             issue_q, issue_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic             dly_valid_q;
  logic [IDX_W-1:0] dly_idx_q;
  logic             done_q;
  logic [IDX_W-1:0] best_idx_q, best_idx_d;
  logic [VEL_W-1:0] best_vel_q, best_vel_d;

  always_comb begin
    issue_d    = issue_q;
    cnt_d      = cnt_q;
    best_idx_d = best_idx_q;
    best_vel_d = best_vel_q;
    if (start_i) begin
      issue_d    = 1'b1;
      cnt_d      = '0;
      best_idx_d = '0;
      best_vel_d = '0;
    end else begin
      if (issue_q) begin
        if (cnt_q == LAST_IDX) begin
          issue_d = 1'b0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      // strict compare keeps the lowest note among equal maxima
      if (dly_valid_q && (rd_data_i > best_vel_q)) begin
        best_idx_d = dly_idx_q;
        best_vel_d = rd_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q     <= 1'b0;
      cnt_q       <= '0;
      dly_valid_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      issue_q     <= issue_d;
      cnt_q       <= cnt_d;
      dly_valid_q <= issue_q && !start_i;
      done_q      <= dly_valid_q && (dly_idx_q == LAST_IDX) && !start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dly_idx_q  <= cnt_q;
    best_idx_q <= best_idx_d;
    best_vel_q <= best_vel_d;
  end

  assign rd_en_o    = issue_q;
  assign rd_addr_o  = cnt_q;
  assign busy_o     = issue_q || dly_valid_q || done_q;
  assign done_o     = done_q;
  assign best_idx_o = best_idx_q;
  assign best_vel_o = best_vel_q;

endmodule

`default_nettype wire

### hdl/note_velocity_peak_meter.sv
// Top level of the note velocity peak meter: command decode, peak and level state.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------------------
//   cfg     | in        | cfg_we_i              | cfg_index_i, cfg_data_i
//   in      | in        | in_valid_i/in_ready_o | in_req_i (command, note, velocity)
//   out     | out       | out_valid_o/out_ready_i | out_rsp_o (peak, velocity, level, redraw)
//
// After reset the store is cleared one entry a cycle, with in_ready_o low until it is done.
// A request that needs no rescan passes through ST_DONE into the output register as soon
// as that register frees, and the block returns to idle for the next request.
// A rescan reads the store one note per cycle, then hands its result over through ST_DONE.
// The output register holds a result while the next request is taken; a second
// finished result waits in the state registers until the output register frees.
`timescale 1ns / 1ps
`default_nettype none

module note_velocity_peak_meter #(
  parameter int unsigned NOTE_COUNT = nvpm_pkg::NOTE_COUNT_DEFAULT
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic                       cfg_index_i,
  input  wire logic [nvpm_pkg::CFG_W-1:0] cfg_data_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire nvpm_pkg::in_req_t          in_req_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output nvpm_pkg::out_rsp_t              out_rsp_o
);
  import nvpm_pkg::*;

  localparam int unsigned      IDX_W    = $clog2(NOTE_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NOTE_COUNT - 1);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  cfg_t             cfg_q;
  logic [IDX_W-1:0] clr_cnt_q, clr_cnt_d;
  logic [IDX_W-1:0] peak_q, peak_d;
  logic [VEL_W-1:0] peak_vel_q, peak_vel_d;
  logic [LEVEL_W-1:0] level_q, level_d;
  logic             redraw_q, redraw_d;
  logic             out_valid_q;
  out_rsp_t         out_rsp_q;

  logic             accept;
  logic             note_ok;
  logic [IDX_W-1:0] note_idx;
  logic             hit_peak;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [VEL_W-1:0] ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic [VEL_W-1:0] ram_rdata;

  logic             scan_start;
  logic             scan_busy;
  logic             scan_done;
  logic [IDX_W-1:0] scan_idx;
  logic [VEL_W-1:0] scan_vel;
  logic             out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign note_ok    = (32'(in_req_i.note) < NOTE_COUNT);
  assign note_idx   = IDX_W'(in_req_i.note);
  assign hit_peak   = note_ok && (note_idx == peak_q);
  assign out_free   = !out_valid_q || out_ready_i;

  // Configuration: plain register writes; the user must make them while idle, the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.decay_step     <= DECAY_STEP_RESET;
      cfg_q.snap_threshold <= SNAP_THRESHOLD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_DECAY_STEP:     cfg_q.decay_step     <= cfg_data_i;
        CFG_SNAP_THRESHOLD: cfg_q.snap_threshold <= cfg_data_i;
        default:            cfg_q                <= cfg_q;
      endcase
    end
  end

  always_comb begin
    state_d    = state_q;
    clr_cnt_d  = clr_cnt_q;
    peak_d     = peak_q;
    peak_vel_d = peak_vel_q;
    level_d    = level_q;
    redraw_d   = redraw_q;
    ram_we     = 1'b0;
    ram_waddr  = note_idx;
    ram_wdata  = in_req_i.velocity;
    scan_start = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        // sweep zeros through the store after reset
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
        if (clr_cnt_q == LAST_IDX) begin
          state_d = ST_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d  = ST_DONE;
          redraw_d = 1'b0;
          unique case (cmd_e'(in_req_i.command))
            CMD_NOTE_ON: begin
              if (note_ok) begin
                ram_we  = 1'b1;
                level_d = in_req_i.velocity;
                if (hit_peak) begin
                  // the peak note was overwritten: find the peak again
                  scan_start = 1'b1;
                  redraw_d   = 1'b1;
                  state_d    = ST_SCAN;
                end else if (in_req_i.velocity > peak_vel_q) begin
                  peak_d     = note_idx;
                  peak_vel_d = in_req_i.velocity;
                  redraw_d   = 1'b1;
                end
              end
            end
            CMD_NOTE_OFF: begin
              if (note_ok) begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                if (hit_peak) begin
                  scan_start = 1'b1;
                  redraw_d   = 1'b1;
                  state_d    = ST_SCAN;
                end
              end
            end
            CMD_TICK: begin
              if (level_q != '0) begin
                redraw_d = 1'b1;
                if ((level_q < cfg_q.snap_threshold) || (level_q < cfg_q.decay_step)) begin
                  level_d = '0;
                end else begin
                  level_d = level_q - cfg_q.decay_step;
                end
              end
            end
            default: begin
              // unused command: report state, no redraw
              redraw_d = 1'b0;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          peak_d     = scan_idx;
          peak_vel_d = scan_vel;
          state_d    = ST_DONE;
        end
      end
      ST_DONE: begin
        // hand the result over once the output register frees
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      peak_q      <= '0;
      peak_vel_q  <= '0;
      level_q     <= '0;
      redraw_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_cnt_q  <= clr_cnt_d;
      peak_q     <= peak_d;
      peak_vel_q <= peak_vel_d;
      level_q    <= level_d;
      redraw_q   <= redraw_d;
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DONE) && out_free) begin
      out_rsp_q.peak_note     <= NOTE_W'(peak_q);
      out_rsp_q.peak_velocity <= peak_vel_q;
      out_rsp_q.level         <= level_q;
      out_rsp_q.redraw        <= redraw_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  nvpm_ram #(
    .NOTE_COUNT (NOTE_COUNT),
    .IDX_W      (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  nvpm_scan #(
    .NOTE_COUNT (NOTE_COUNT),
    .IDX_W      (IDX_W)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (scan_start),
    .rd_en_o    (ram_re),
    .rd_addr_o  (ram_raddr),
    .rd_data_i  (ram_rdata),
    .busy_o     (scan_busy),
    .done_o     (scan_done),
    .best_idx_o (scan_idx),
    .best_vel_o (scan_vel)
  );

`ifndef SYNTH
  // no request is taken while a rescan walks the store
  a_no_accept_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_busy |-> !in_ready_o)
    else $error("request accepted during rescan");

  // a finished rescan always moves on to result handoff
  a_scan_done_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) && scan_done |=> (state_q == ST_DONE))
    else $error("rescan finished without result handoff");

  // a tick on a zero level changes nothing
  a_tick_zero_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_req_i.command == CMD_TICK) && (level_q == '0) |=>
      !redraw_q && (level_q == '0))
    else $error("tick at zero level changed the meter");

  // a note-on in range loads its velocity into the level
  a_note_on_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_req_i.command == CMD_NOTE_ON) && note_ok |=>
      (level_q == $past(in_req_i.velocity)))
    else $error("note-on did not load the level");
`endif

endmodule

`default_nettype wire

### tb/note_velocity_peak_meter_test.sv
// Self-checking testbench for the note velocity peak meter: directed and random requests.
`timescale 1ns / 1ps

module note_velocity_peak_meter_test;
  import nvpm_pkg::*;

  // Command 3 is not decoded by the block; it must leave all state alone.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned NOTES = NOTE_COUNT_DEFAULT;
  // The watchdog limit covers a rescan and the clearing pass after reset,
  // plus the longest stall on either side, taken many times over.
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned RANDOM_PHASE_LEN = 200;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_index_i;
  logic [CFG_W-1:0] cfg_data_i;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_req_t in_req_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_rsp_t out_rsp_o;

  note_velocity_peak_meter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  // Predicted meter state, advanced once per accepted request.
  logic [VEL_W-1:0] vel_store [NOTES];
  logic [NOTE_W-1:0] peak_note;
  logic [LEVEL_W-1:0] meter_level;
  logic [CFG_W-1:0] decay_step;
  logic [CFG_W-1:0] snap_threshold;

  in_req_t pending_reqs[$];       // requests waiting for the driver
  out_rsp_t expected_rsps[$];     // predicted results, oldest first
  int unsigned pushed_count = 0;  // requests queued so far
  int unsigned taken_count = 0;   // requests accepted by the block
  int unsigned idle_cycles = 0;
  bit req_taken = 1'b0;           // set on accept, cleared by the driver
  bit calm = 1'b0;                // no idling on either side while set
  bit failed = 1'b0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Rescan: lowest note number among those holding the greatest velocity.
  function automatic logic [NOTE_W-1:0] loudest_note();
    logic [NOTE_W-1:0] best;
    best = '0;
    for (int i = 1; i < NOTES; i++) begin
      if (vel_store[i] > vel_store[best]) best = NOTE_W'(i);
    end
    return best;
  endfunction

  // Advance the predicted meter by one request and return its result.
  function automatic out_rsp_t meter_step(in_req_t req);
    out_rsp_t rsp;
    logic redraw;
    redraw = 1'b0;
    case (req.command)
      CMD_NOTE_ON: begin
        vel_store[req.note] = req.velocity;
        meter_level = req.velocity;
        // Compare against the peak's entry after the store write, so a hit
        // on the peak note itself never counts as beating it.
        if (req.velocity > vel_store[peak_note]) begin
          peak_note = req.note;
          redraw = 1'b1;
        end else if (req.note == peak_note) begin
          peak_note = loudest_note();
          redraw = 1'b1;
        end
      end
      CMD_NOTE_OFF: begin
        vel_store[req.note] = '0;
        if (req.note == peak_note) begin
          peak_note = loudest_note();
          redraw = 1'b1;
        end
      end
      CMD_TICK: begin
        // A zero level stays put and asks for no redraw; otherwise snap to
        // zero below the threshold, saturate when the step is too big.
        if (meter_level != 0) begin
          if (meter_level < snap_threshold) meter_level = '0;
          else if (meter_level < decay_step) meter_level = '0;
          else meter_level = meter_level - decay_step;
          redraw = 1'b1;
        end
      end
      default: ;
    endcase
    rsp.peak_note = peak_note;
    rsp.peak_velocity = vel_store[peak_note];
    rsp.level = meter_level;
    rsp.redraw = redraw;
    return rsp;
  endfunction

  // Request driver: change inputs on the falling edge only. Hold a request
  // until it is taken, then either present the next one at once (valid stays
  // high, one assignment) or drop valid for a random gap.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!(in_valid_i && !req_taken)) begin
      req_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        in_req_i <= pending_reqs.pop_front();
        in_valid_i <= 1'b1;
        send_gap = calm ? 0 : gap_len();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result sink: stall at random, except in calm stretches.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) stall_left = gap_len();
    end
  end

  // Monitor: sample both handshakes on the rising edge, predict on every
  // accepted request, check every accepted result against the oldest
  // prediction, and watch for a stuck block.
  always @(posedge clk_i) begin
    out_rsp_t want;
    bit moved;
    moved = 1'b0;
    if (rst_ni && in_valid_i && in_ready_o) begin
      expected_rsps.push_back(meter_step(in_req_i));
      req_taken = 1'b1;
      taken_count++;
      moved = 1'b1;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      moved = 1'b1;
      if (expected_rsps.size() == 0) begin
        $error("result with no request pending: peak_note %0d level %0d",
               out_rsp_o.peak_note, out_rsp_o.level);
        failed = 1'b1;
      end else begin
        want = expected_rsps.pop_front();
        if (out_rsp_o.peak_note !== want.peak_note) begin
          $error("peak_note: expected %0d, got %0d", want.peak_note, out_rsp_o.peak_note);
          failed = 1'b1;
        end
        if (out_rsp_o.peak_velocity !== want.peak_velocity) begin
          $error("peak_velocity: expected %0d, got %0d",
                 want.peak_velocity, out_rsp_o.peak_velocity);
          failed = 1'b1;
        end
        if (out_rsp_o.level !== want.level) begin
          $error("level: expected %0d, got %0d", want.level, out_rsp_o.level);
          failed = 1'b1;
        end
        if (out_rsp_o.redraw !== want.redraw) begin
          $error("redraw: expected %0d, got %0d", want.redraw, out_rsp_o.redraw);
          failed = 1'b1;
        end
      end
    end
    if (moved) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("note_velocity_peak_meter: mismatch");
      $finish;
    end
  end

  task automatic push_req(logic [1:0] cmd, logic [NOTE_W-1:0] note,
                          logic [VEL_W-1:0] vel);
    in_req_t req;
    req.command = cmd;
    req.note = note;
    req.velocity = vel;
    pending_reqs.push_back(req);
    pushed_count++;
  endtask

  // Hold until every queued request is taken and every result has come.
  task automatic wait_drained();
    while (taken_count != pushed_count || expected_rsps.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    if (idx == CFG_DECAY_STEP) decay_step = val;
    else snap_threshold = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Drain, reprogram both registers, then hand the next batch to the driver
  // just after a rising edge so it never races the driver's pop.
  task automatic set_meter(logic [CFG_W-1:0] step, logic [CFG_W-1:0] thresh);
    wait_drained();
    write_reg(CFG_DECAY_STEP, step);
    write_reg(CFG_SNAP_THRESHOLD, thresh);
    @(posedge clk_i);
  endtask

  // Random traffic: note-on/note-off pairs on a mix of a narrow note window
  // (so the peak note is hit often and rescans run) and the full range,
  // bursts of ticks, and a little unused-command noise.
  task automatic random_phase(int unsigned count);
    logic [NOTE_W-1:0] held[$];
    logic [NOTE_W-1:0] base;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0] vel;
    int unsigned made;
    int unsigned r;
    int unsigned k;
    base = NOTE_W'($urandom_range(0, 120));
    made = 0;
    while (made < count) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 1) != 0) note = base + NOTE_W'($urandom_range(0, 7));
      else note = NOTE_W'($urandom_range(0, 127));
      if (r < 45) begin
        k = $urandom_range(0, 9);
        if (k < 2) vel = 7'd127;
        else if (k < 3) vel = '0;
        else if (k < 5) vel = VEL_W'($urandom_range(0, 15));
        else vel = VEL_W'($urandom_range(0, 127));
        push_req(CMD_NOTE_ON, note, vel);
        held.push_back(note);
        made++;
      end else if (r < 70) begin
        if (held.size() > 0 && $urandom_range(0, 9) != 0) begin
          k = $urandom_range(0, held.size() - 1);
          note = held[k];
          held.delete(k);
        end
        push_req(CMD_NOTE_OFF, note, VEL_W'($urandom_range(0, 127)));
        made++;
      end else if (r < 96) begin
        repeat ($urandom_range(1, 6)) begin
          push_req(CMD_TICK, NOTE_W'($urandom_range(0, 127)),
                   VEL_W'($urandom_range(0, 127)));
          made++;
        end
      end else begin
        push_req(CMD_UNUSED, NOTE_W'($urandom_range(0, 127)),
                 VEL_W'($urandom_range(0, 127)));
        made++;
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_DECAY_STEP;
    cfg_data_i = '0;
    for (int i = 0; i < NOTES; i++) vel_store[i] = '0;
    peak_note = '0;
    meter_level = '0;
    decay_step = DECAY_STEP_RESET;
    snap_threshold = SNAP_THRESHOLD_RESET;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // Let the store clearing pass finish before touching the registers.
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);

    // Directed, reset settings written back explicitly.
    set_meter(DECAY_STEP_RESET, SNAP_THRESHOLD_RESET);
    push_req(CMD_TICK, 7'd0, 7'd0);         // tick at zero level
    push_req(CMD_NOTE_OFF, 7'd0, 7'd127);   // rescan over an empty store
    push_req(CMD_NOTE_ON, 7'd127, 7'd127);  // new peak at the top note
    push_req(CMD_NOTE_ON, 7'd0, 7'd0);
    push_req(CMD_NOTE_ON, 7'd5, 7'd127);    // tie with the peak: no move
    push_req(CMD_NOTE_ON, 7'd127, 7'd60);   // hit the peak without beating it
    push_req(CMD_NOTE_ON, 7'd64, 7'd127);
    push_req(CMD_NOTE_OFF, 7'd5, 7'd0);     // peak off, rescan finds note 64
    push_req(CMD_UNUSED, 7'd85, 7'd42);
    push_req(CMD_NOTE_ON, 7'd42, 7'd85);    // note on without a new peak
    push_req(CMD_TICK, 7'd42, 7'd85);
    push_req(CMD_NOTE_ON, 7'd64, 7'd0);     // zero velocity on the peak note
    push_req(CMD_TICK, 7'd0, 7'd0);
    push_req(CMD_NOTE_ON, 7'd3, 7'd12);
    push_req(CMD_TICK, 7'd127, 7'd127);
    push_req(CMD_TICK, 7'd127, 7'd127);     // below threshold: snap to zero

    // Directed: step no smaller than any level.
    set_meter(7'd127, 7'd0);
    push_req(CMD_NOTE_ON, 7'd9, 7'd100);
    push_req(CMD_TICK, 7'd1, 7'd1);         // saturate at zero
    push_req(CMD_NOTE_OFF, 7'd42, 7'd0);
    push_req(CMD_TICK, 7'd0, 7'd0);
    push_req(CMD_UNUSED, 7'd127, 7'd127);

    // Random phases across extreme and random settings; one runs calm.
    set_meter(7'd0, 7'd0);
    random_phase(RANDOM_PHASE_LEN);
    set_meter(7'd127, 7'd127);
    random_phase(RANDOM_PHASE_LEN);
    set_meter(DECAY_STEP_RESET, SNAP_THRESHOLD_RESET);
    random_phase(RANDOM_PHASE_LEN);
    set_meter(7'd1, 7'd127);
    calm = 1'b1;
    random_phase(RANDOM_PHASE_LEN);
    set_meter(7'd127, 7'd1);
    calm = 1'b0;
    random_phase(RANDOM_PHASE_LEN);
    set_meter(CFG_W'($urandom_range(0, 127)), CFG_W'($urandom_range(0, 127)));
    random_phase(RANDOM_PHASE_LEN);
    set_meter(CFG_W'($urandom_range(0, 20)), CFG_W'($urandom_range(0, 40)));
    random_phase(RANDOM_PHASE_LEN);

    // Drain, then keep watching for stray results.
    wait_drained();
    repeat (NOTES + 8) @(posedge clk_i);
    if (!failed && expected_rsps.size() == 0) begin
      $display("note_velocity_peak_meter: match");
    end else begin
      $display("note_velocity_peak_meter: mismatch");
    end
    $finish;
  end

endmodule
